// ===== src/ght_pkg.sv =====
// Shared types and constants for the generational handle table.
// Holds the command record that travels from the front part to the back part.
// No dependencies.
package ght_pkg;

	localparam int SLOTS  = 256;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int GEN_W  = 32;
	localparam int PAY_W  = 32;
	localparam int HAND_W = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 3;
	localparam int KIND_W = 2;

	localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	localparam logic [KIND_W-1:0] K_ACQ  = 2'd0;
	localparam logic [KIND_W-1:0] K_LOOK = 2'd1;
	localparam logic [KIND_W-1:0] K_REL  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_NONE  = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 3'd2;
	localparam logic [STAT_W-1:0] ST_STALE = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              none_h;
		logic              idx_hi;
		logic [IDX_W-1:0]  idx;
		logic [GEN_W-1:0]  gen;
		logic [PAY_W-1:0]  payload;
	} cmd_t;

endpackage

// ===== src/ght_front.sv =====
// Front part of the generational handle table: accepts requests and classifies them.
// Depends on ght_pkg.
module ght_front (
	input  logic                      start,
	input  logic                      full,
	input  logic [ght_pkg::OP_W-1:0]   opcode,
	input  logic [ght_pkg::PAY_W-1:0]  payload_in,
	input  logic [ght_pkg::HAND_W-1:0] slot_index_in,
	input  logic [ght_pkg::GEN_W-1:0]  generation_in,
	output logic                      push,
	output ght_pkg::cmd_t              cmd
);

	always_comb begin
		unique case (opcode)
			ght_pkg::OP_ACQUIRE: cmd.kind = ght_pkg::K_ACQ;
			ght_pkg::OP_RELEASE: cmd.kind = ght_pkg::K_REL;
			default:             cmd.kind = ght_pkg::K_LOOK;
		endcase
		cmd.none_h  = (slot_index_in == '0) && (generation_in == '0);
		cmd.idx_hi  = |slot_index_in[ght_pkg::HAND_W-1:ght_pkg::IDX_W];
		cmd.idx     = slot_index_in[ght_pkg::IDX_W-1:0];
		cmd.gen     = generation_in;
		cmd.payload = payload_in;
	end

	assign push = start & ~full;

endmodule

// ===== src/ght_queue.sv =====
// Two-entry command queue between the front and back parts of the handle table.
// Depends on ght_pkg.
module ght_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ght_pkg::cmd_t wdata,
	input  logic          pop,
	output ght_pkg::cmd_t head,
	output logic          not_empty,
	output logic          full
);

	ght_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);

endmodule

// ===== src/ght_back.sv =====
// Back part of the generational handle table: slot state, free stack and execution.
// Holds the generation, payload and free stack memories. Depends on ght_pkg.
module ght_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  ght_pkg::cmd_t              q_head,
	output logic                      q_pop,
	output logic                      done,
	output logic [ght_pkg::STAT_W-1:0] status,
	output logic [ght_pkg::IDX_W-1:0]  slot_index_out,
	output logic [ght_pkg::GEN_W-1:0]  generation_out,
	output logic [ght_pkg::PAY_W-1:0]  payload_out
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	localparam logic [ght_pkg::CNT_W-1:0] SLOTS_C = ght_pkg::CNT_W'(ght_pkg::SLOTS);

	logic [1:0]                  state_q;
	logic [ght_pkg::CNT_W-1:0]    high_water_q;
	logic [ght_pkg::CNT_W-1:0]    free_count_q;
	logic [ght_pkg::SLOTS-1:0]    occ_q;
	logic [ght_pkg::SLOTS-1:0]    gvalid_q;
	ght_pkg::cmd_t                cmd_q;
	logic [ght_pkg::IDX_W-1:0]    slot_q;
	logic                        popped_q;
	logic                        full_q;
	logic                        done_q;
	logic [ght_pkg::STAT_W-1:0]   status_q;
	logic [ght_pkg::IDX_W-1:0]    slot_out_q;
	logic [ght_pkg::GEN_W-1:0]    gen_out_q;
	logic [ght_pkg::PAY_W-1:0]    pay_out_q;

	logic [ght_pkg::IDX_W-1:0]    stack_mem [ght_pkg::SLOTS];
	logic [ght_pkg::GEN_W-1:0]    gen_mem   [ght_pkg::SLOTS];
	logic [ght_pkg::PAY_W-1:0]    pay_mem   [ght_pkg::SLOTS];
	logic [ght_pkg::IDX_W-1:0]    stack_rd_q;
	logic [ght_pkg::GEN_W-1:0]    gen_rd_q;
	logic [ght_pkg::PAY_W-1:0]    pay_rd_q;

	logic                        exec;
	logic [ght_pkg::GEN_W-1:0]    gen_cur;
	logic [ght_pkg::GEN_W-1:0]    gen_next;
	logic                        range_bad;
	logic [ght_pkg::STAT_W-1:0]   chk;
	logic                        acq_ok;
	logic                        rel_ok;
	logic                        push_ok;
	logic [ght_pkg::IDX_W-1:0]    stack_ra;
	logic [ght_pkg::IDX_W-1:0]    stack_wa;

	assign exec      = (state_q == S_EXEC);
	assign gen_cur   = gvalid_q[slot_q] ? gen_rd_q : ght_pkg::GEN_W'(1);
	assign gen_next  = gen_cur + ght_pkg::GEN_W'(1);
	assign range_bad = cmd_q.idx_hi || ({1'b0, cmd_q.idx} >= high_water_q);

	always_comb begin
		if (cmd_q.none_h) begin
			chk = ght_pkg::ST_NONE;
		end else if (range_bad) begin
			chk = ght_pkg::ST_RANGE;
		end else if (!occ_q[slot_q] || (gen_cur != cmd_q.gen)) begin
			chk = ght_pkg::ST_STALE;
		end else begin
			chk = ght_pkg::ST_OK;
		end
	end

	assign acq_ok   = exec && (cmd_q.kind == ght_pkg::K_ACQ) && !full_q;
	assign rel_ok   = exec && (cmd_q.kind == ght_pkg::K_REL) && (chk == ght_pkg::ST_OK);
	assign push_ok  = rel_ok && (free_count_q < SLOTS_C);
	assign stack_ra = ght_pkg::IDX_W'(free_count_q - ght_pkg::CNT_W'(1));
	assign stack_wa = free_count_q[ght_pkg::IDX_W-1:0];
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			stack_mem[stack_wa] <= slot_q;
		end
		stack_rd_q <= stack_mem[stack_ra];
	end

	always_ff @(posedge clk) begin
		if (rel_ok) begin
			gen_mem[slot_q] <= gen_next;
		end
		gen_rd_q <= gen_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (acq_ok) begin
			pay_mem[slot_q] <= cmd_q.payload;
		end
		pay_rd_q <= pay_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			high_water_q <= '0;
			free_count_q <= '0;
			occ_q        <= '0;
			gvalid_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= exec;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if ((q_head.kind == ght_pkg::K_ACQ) && (free_count_q != '0)) begin
							state_q <= S_POP;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_POP: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					if (acq_ok) begin
						occ_q[slot_q] <= 1'b1;
						if (popped_q) begin
							free_count_q <= free_count_q - ght_pkg::CNT_W'(1);
						end else begin
							high_water_q <= high_water_q + ght_pkg::CNT_W'(1);
						end
					end
					if (rel_ok) begin
						occ_q[slot_q]    <= 1'b0;
						gvalid_q[slot_q] <= 1'b1;
					end
					if (push_ok) begin
						free_count_q <= free_count_q + ght_pkg::CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
			if ((q_head.kind == ght_pkg::K_ACQ) && (free_count_q != '0)) begin
				popped_q <= 1'b1;
				full_q   <= 1'b0;
			end else if (q_head.kind == ght_pkg::K_ACQ) begin
				popped_q <= 1'b0;
				slot_q   <= high_water_q[ght_pkg::IDX_W-1:0];
				full_q   <= (high_water_q >= SLOTS_C);
			end else begin
				popped_q <= 1'b0;
				full_q   <= 1'b0;
				slot_q   <= q_head.idx;
			end
		end else if (state_q == S_POP) begin
			slot_q <= stack_rd_q;
		end
		if (exec) begin
			if (cmd_q.kind == ght_pkg::K_ACQ) begin
				pay_out_q <= '0;
				if (full_q) begin
					status_q   <= ght_pkg::ST_FULL;
					slot_out_q <= '0;
					gen_out_q  <= '0;
				end else begin
					status_q   <= ght_pkg::ST_OK;
					slot_out_q <= slot_q;
					gen_out_q  <= gen_cur;
				end
			end else begin
				status_q   <= chk;
				slot_out_q <= '0;
				gen_out_q  <= '0;
				if ((cmd_q.kind == ght_pkg::K_LOOK) && (chk == ght_pkg::ST_OK)) begin
					pay_out_q <= pay_rd_q;
				end else begin
					pay_out_q <= '0;
				end
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign slot_index_out = slot_out_q;
	assign generation_out = gen_out_q;
	assign payload_out    = pay_out_q;

endmodule

// ===== src/generational_handle_table_unit.sv =====
// Top level of the generational handle table.
// Instantiates ght_front, ght_queue and ght_back; depends on ght_pkg.
//
// Usage: a request is transferred at a rising edge where start is high and busy is low.
// opcode selects acquire, lookup or release (the unused code acts as a lookup).
// Each request produces one result, shown for exactly one cycle with done high;
// the receiver must take it then, since it cannot hold results off.
// Requests enter a two-entry queue, so busy rises only when the queue is full.
// The execution sequencer handles one request at a time: a lookup, a release or
// an acquire of a never-used slot passes through the read and execute states, and
// an acquire that reuses a freed index first passes through a pop state, because
// the free stack read must finish before the slot's generation can be read. A new
// request leaves the queue only when the sequencer has returned to idle.
// Results leave in request order. Reset clears the queue, the occupancy and
// generation valid bits, the high-water mark and the free count at once; no
// clearing pass is needed, and requests are taken in the first cycle after reset.
module generational_handle_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ght_pkg::OP_W-1:0]   opcode,
	input  logic [ght_pkg::PAY_W-1:0]  payload_in,
	input  logic [ght_pkg::HAND_W-1:0] slot_index_in,
	input  logic [ght_pkg::GEN_W-1:0]  generation_in,
	output logic                      done,
	output logic [ght_pkg::STAT_W-1:0] status,
	output logic [ght_pkg::IDX_W-1:0]  slot_index_out,
	output logic [ght_pkg::GEN_W-1:0]  generation_out,
	output logic [ght_pkg::PAY_W-1:0]  payload_out
);

	ght_pkg::cmd_t front_cmd;
	ght_pkg::cmd_t q_head;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_valid;

	ght_front u_front (
		.start         (start),
		.full          (q_full),
		.opcode        (opcode),
		.payload_in    (payload_in),
		.slot_index_in (slot_index_in),
		.generation_in (generation_in),
		.push          (push),
		.cmd           (front_cmd)
	);

	ght_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (front_cmd),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_valid),
		.full      (q_full)
	);

	ght_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (pop),
		.done           (done),
		.status         (status),
		.slot_index_out (slot_index_out),
		.generation_out (generation_out),
		.payload_out    (payload_out)
	);

	assign busy = q_full;

endmodule
